>>> src/poc_pkg.sv
// Shared types, constants and constant tables of the palette overlay compositor.
// Used by the front part, the back part and the top level; it depends on nothing.
package poc_pkg;

  // Kind of item carried from the front part to the back part.
  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // One classified item in the issue queue.
  typedef struct packed {
    op_e         op;
    logic        hit_a;   // idx_a lies inside the palette
    logic [7:0]  idx_a;   // base index, or entry index of a palette write
    logic        hit_b;   // idx_b lies inside the palette
    logic [7:0]  idx_b;   // top index
    logic        top_nz;  // top layer is opaque
    logic [31:0] data;    // overlay ARGB, or entry RGB in bits 23..0
  } cmd_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // Luminance weights, sum of weights is 256.
  localparam logic [15:0] LUM_R_W = 16'd77;
  localparam logic [15:0] LUM_G_W = 16'd150;
  localparam logic [15:0] LUM_B_W = 16'd29;

  // End points of the green shade ramp.
  localparam logic [7:0] RAMP_R_LO = 8'h0F;
  localparam logic [7:0] RAMP_R_HI = 8'h9B;
  localparam logic [7:0] RAMP_G_LO = 8'h38;
  localparam logic [7:0] RAMP_G_HI = 8'hBC;
  localparam logic [7:0] RAMP_B    = 8'h0F;

  // Power-on palette contents: a grey ramp with a few custom colors.
  function automatic logic [23:0] pal_default(input logic [7:0] idx);
    logic [23:0] col;
    unique case (idx)
      8'd15:   col = {8'd255, 8'd255, 8'd255};
      8'd22:   col = {8'd176, 8'd144, 8'd64};
      8'd32:   col = {8'd44, 8'd160, 8'd84};
      8'd46:   col = {8'd255, 8'd220, 8'd64};
      8'd69:   col = {8'd235, 8'd80, 8'd80};
      8'd80:   col = {8'd28, 8'd46, 8'd78};
      8'd82:   col = {8'd88, 8'd136, 8'd188};
      8'd83:   col = {8'd112, 8'd164, 8'd216};
      8'd84:   col = {8'd56, 8'd104, 8'd172};
      8'd89:   col = {8'd232, 8'd188, 8'd56};
      8'd127:  col = {8'd108, 8'd200, 8'd148};
      8'd140:  col = {8'd198, 8'd202, 8'd212};
      8'd141:  col = {8'd170, 8'd176, 8'd188};
      8'd157:  col = {8'd255, 8'd140, 8'd64};
      8'd181:  col = {8'd244, 8'd148, 8'd64};
      8'd186:  col = {8'd132, 8'd138, 8'd150};
      8'd190:  col = {8'd76, 8'd212, 8'd116};
      8'd226:  col = {8'd58, 8'd82, 8'd122};
      8'd230:  col = {8'd35, 8'd52, 8'd79};
      8'd235:  col = {8'd226, 8'd230, 8'd238};
      default: col = {idx, idx, idx};
    endcase
    return col;
  endfunction

  // Exact quotient x / 255 for any x up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] acc;
    acc = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return acc[15:8];
  endfunction

  // Single-precision value as significand and binary exponent, used only
  // while the constant tables are built.
  typedef struct packed {
    logic [63:0] m;
    int          e;
  } sfl_t;

  // Round v * 2^e to a 24-bit significand, ties to even.
  function automatic sfl_t sf_round(input logic [63:0] v, input int e);
    sfl_t        r;
    int          n;
    int          s;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    n = 0;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) n = k + 1;
    end
    if (n > 24) begin
      s    = n - 24;
      keep = v >> s;
      rem  = v & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 64'd1;
      if (keep == (64'd1 << 24)) begin
        keep = keep >> 1;
        s    = s + 1;
      end
      r.m = keep;
      r.e = e + s;
    end else begin
      r.m = v << (24 - n);
      r.e = e - (24 - n);
    end
    return r;
  endfunction

  function automatic sfl_t sf_mul(input sfl_t a, input sfl_t b);
    return sf_round(a.m * b.m, a.e + b.e);
  endfunction

  // Sum, or difference with a larger than b.
  function automatic sfl_t sf_addsub(input sfl_t a, input sfl_t b, input logic sub);
    int          lo;
    logic [63:0] va;
    logic [63:0] vb;
    lo = (a.e < b.e) ? a.e : b.e;
    va = a.m << (a.e - lo);
    vb = b.m << (b.e - lo);
    return sf_round(sub ? (va - vb) : (va + vb), lo);
  endfunction

  // Smoothstep of lum / 255, scaled to 0..255 and rounded, as binary32 gives it.
  function automatic logic [7:0] smooth_ti(input int lum);
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    sfl_t        x;
    sfl_t        xx;
    sfl_t        two_x;
    sfl_t        three;
    sfl_t        d;
    sfl_t        t;
    sfl_t        c255;
    sfl_t        half;
    sfl_t        h;
    int          sh;
    if (lum == 0) return 8'd0;
    num     = 64'(lum) << 40;
    q       = num / 64'd255;
    rem     = num % 64'd255;
    x       = sf_round(q * 64'd2 + 64'(rem != 64'd0), -41);
    xx      = sf_mul(x, x);
    two_x.m = x.m;
    two_x.e = x.e + 1;
    three.m = 64'd3 << 22;
    three.e = -22;
    d       = sf_addsub(three, two_x, 1'b1);
    t       = sf_mul(xx, d);
    c255.m  = 64'd255 << 16;
    c255.e  = -16;
    half.m  = 64'd1 << 23;
    half.e  = -24;
    h       = sf_addsub(sf_mul(t, c255), half, 1'b0);
    if (h.e >= 0) return 8'd255;
    sh = -h.e;
    if (sh >= 64) return 8'd0;
    return 8'(h.m >> sh);
  endfunction

  // Luminance to green ramp color: red in bits 15..8, green in bits 7..0.
  typedef logic [15:0] green_rom_t [256];

  function automatic green_rom_t build_green_rom();
    green_rom_t rom;
    int         ti;
    int         gr;
    int         gg;
    for (int l = 0; l < 256; l++) begin
      ti     = int'(smooth_ti(l));
      gr     = int'(RAMP_R_LO) + ((int'(RAMP_R_HI) - int'(RAMP_R_LO)) * ti) / 255;
      gg     = int'(RAMP_G_LO) + ((int'(RAMP_G_HI) - int'(RAMP_G_LO)) * ti) / 255;
      rom[l] = {8'(gr), 8'(gg)};
    end
    return rom;
  endfunction

  localparam green_rom_t GREEN_ROM = build_green_rom();

endpackage

>>> src/poc_ram.sv
// Generic RAM with one write port and two registered read ports.
// Stand-alone; no package needed.
module poc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // Read ports; data holds while re_i is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

>>> src/poc_front.sv
// Front part: accepts input items, classifies them and holds them in the issue queue.
// Depends on poc_pkg for the queue entry type.
module poc_front
  import poc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  base_index_i,
  input  logic [31:0] overlay_argb_i,
  input  logic [7:0]  top_index_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  entry_red_i,
  input  logic [7:0]  entry_green_i,
  input  logic [7:0]  entry_blue_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [8:0]    DEPTH_LIM = 9'(PALETTE_DEPTH);

  cmd_t          cls;
  cmd_t          queue_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push;
  logic          pop;

  // Classify the incoming item and pack it for the back part.
  always_comb begin
    cls.op     = op_e'(func_i);
    cls.idx_a  = (cls.op == OP_WRITE) ? entry_index_i : base_index_i;
    cls.hit_a  = ({1'b0, cls.idx_a} < DEPTH_LIM);
    cls.idx_b  = top_index_i;
    cls.hit_b  = ({1'b0, top_index_i} < DEPTH_LIM);
    cls.top_nz = (top_index_i != 8'd0);
    cls.data   = (cls.op == OP_WRITE) ?
                 {8'h00, entry_red_i, entry_green_i, entry_blue_i} : overlay_argb_i;
  end

  assign in_ready_o  = (count_q != CW'(QUEUE_DEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= cls;
  end

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    if (pop)  rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    if (push && !pop) count_d = count_q + CW'(1);
    if (pop && !push) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> src/poc_back.sv
// Back part: palette writes, palette lookups, overlay blend, top override and green
// mapping, then the output register. Depends on poc_pkg and poc_ram.
module poc_back
  import poc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  input  logic        green_mode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pixel_argb_o
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic                     adv;
  logic                     is_write;
  logic                     pix_pop;
  logic                     pal_we;
  logic [AW-1:0]            addr_a;
  logic [AW-1:0]            addr_b;
  logic [PALETTE_DEPTH-1:0] pal_vld_q;
  logic [23:0]              ram_a;
  logic [23:0]              ram_b;

  // Stage 1: side data that travels with the palette read.
  logic        s1_valid_q;
  logic        s1_hit_a_q, s1_hit_b_q;
  logic        s1_vld_a_q, s1_vld_b_q;
  logic [7:0]  s1_idx_a_q, s1_idx_b_q;
  logic        s1_top_nz_q;
  logic [31:0] s1_ovl_q;

  // Stage 2: blend sums and the alternatives.
  logic        s2_valid_q;
  logic [15:0] s2_sum_r_q, s2_sum_g_q, s2_sum_b_q;
  logic        s2_a_zero_q, s2_a_full_q, s2_top_nz_q;
  logic [23:0] s2_base_q, s2_ovl_q, s2_top_q;

  // Stage 3 and 4: composited color, then its luminance.
  logic        s3_valid_q;
  logic [23:0] s3_col_q;
  logic        s4_valid_q;
  logic [23:0] s4_col_q;
  logic [7:0]  s4_lum_q;

  logic        out_valid_q;
  logic [31:0] out_data_q;

  // Whole pipeline moves when the output register can take a transfer.
  assign adv         = !out_valid_q || out_ready_i;
  assign is_write    = (cmd_i.op == OP_WRITE);
  assign cmd_ready_o = is_write || adv;
  assign pix_pop     = cmd_valid_i && !is_write && adv;
  assign pal_we      = cmd_valid_i && is_write && cmd_i.hit_a;
  assign addr_a      = cmd_i.idx_a[AW-1:0];
  assign addr_b      = cmd_i.idx_b[AW-1:0];

  poc_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_pal_ram (
    .clk_i     (clk_i),
    .we_i      (pal_we),
    .waddr_i   (addr_a),
    .wdata_i   (cmd_i.data[23:0]),
    .re_i      (pix_pop),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  // Written-entry flags; an unwritten entry reads its power-on color.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
    end else if (pal_we) begin
      pal_vld_q[addr_a] <= 1'b1;
    end
  end

  // Stage 1 side data, captured together with the memory read.
  always_ff @(posedge clk_i) begin
    if (pix_pop) begin
      s1_hit_a_q  <= cmd_i.hit_a;
      s1_hit_b_q  <= cmd_i.hit_b;
      s1_vld_a_q  <= cmd_i.hit_a && pal_vld_q[addr_a];
      s1_vld_b_q  <= cmd_i.hit_b && pal_vld_q[addr_b];
      s1_idx_a_q  <= cmd_i.idx_a;
      s1_idx_b_q  <= cmd_i.idx_b;
      s1_top_nz_q <= cmd_i.top_nz;
      s1_ovl_q    <= cmd_i.data;
    end
  end

  // Resolve the palette colors and form the weighted sums of the blend.
  logic [23:0] base_col, top_col;
  logic [7:0]  alpha, ialpha;
  logic [15:0] sum_r, sum_g, sum_b;

  always_comb begin
    base_col = !s1_hit_a_q ? 24'h000000 :
               (s1_vld_a_q ? ram_a : pal_default(s1_idx_a_q));
    top_col  = !s1_hit_b_q ? 24'h000000 :
               (s1_vld_b_q ? ram_b : pal_default(s1_idx_b_q));
    alpha    = s1_ovl_q[31:24];
    ialpha   = ~alpha;
    sum_r    = 16'(s1_ovl_q[23:16]) * 16'(alpha) + 16'(base_col[23:16]) * 16'(ialpha);
    sum_g    = 16'(s1_ovl_q[15:8]) * 16'(alpha) + 16'(base_col[15:8]) * 16'(ialpha);
    sum_b    = 16'(s1_ovl_q[7:0]) * 16'(alpha) + 16'(base_col[7:0]) * 16'(ialpha);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sum_r_q  <= sum_r;
      s2_sum_g_q  <= sum_g;
      s2_sum_b_q  <= sum_b;
      s2_a_zero_q <= (alpha == ALPHA_CLEAR);
      s2_a_full_q <= (alpha == ALPHA_OPAQUE);
      s2_top_nz_q <= s1_top_nz_q;
      s2_base_q   <= base_col;
      s2_ovl_q    <= s1_ovl_q[23:0];
      s2_top_q    <= top_col;
    end
  end

  // Pick the composited color: top layer, then overlay rules.
  logic [23:0] comp_col;

  always_comb begin
    priority if (s2_top_nz_q) begin
      comp_col = s2_top_q;
    end else if (s2_a_zero_q) begin
      comp_col = s2_base_q;
    end else if (s2_a_full_q) begin
      comp_col = s2_ovl_q;
    end else begin
      comp_col = {div255(s2_sum_r_q), div255(s2_sum_g_q), div255(s2_sum_b_q)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) s3_col_q <= comp_col;
  end

  // Luminance of the composited color.
  logic [15:0] lum_sum;

  assign lum_sum = LUM_R_W * 16'(s3_col_q[23:16]) + LUM_G_W * 16'(s3_col_q[15:8]) +
                   LUM_B_W * 16'(s3_col_q[7:0]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_col_q <= s3_col_q;
      s4_lum_q <= lum_sum[15:8];
    end
  end

  // Green ramp mapping and the output register.
  logic [15:0] green_rg;
  logic [31:0] out_data;

  assign green_rg = GREEN_ROM[s4_lum_q];
  assign out_data = green_mode_i ? {ALPHA_OPAQUE, green_rg, RAMP_B} :
                                   {ALPHA_OPAQUE, s4_col_q};

  always_ff @(posedge clk_i) begin
    if (adv) out_data_q <= out_data;
  end

  // Valid flags of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= pix_pop;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_argb_o = out_data_q;

endmodule

>>> src/palette_overlay_compositor_core.sv
// Top level of the palette overlay compositor: configuration register, front part
// and back part. Depends on poc_pkg, poc_front, poc_back and poc_ram.
//
//   Channel   Direction  Handshake                     Payload
//   in        input      in_valid_i / in_ready_o       func_i .. entry_blue_i
//   out       output     out_valid_o / out_ready_i     pixel_argb_o
//   cfg       input      psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One item is taken per clock while the issue queue has room; a pixel result passes
// through the queue, four pipeline stages and the output register.
// After reset the palette holds its power-on colors at once; no clearing pass runs.
// An output stall freezes the back pipeline; the issue queue keeps taking items
// until it is full, and a palette write at the queue head drains even during a stall.
module palette_overlay_compositor_core
  import poc_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  base_index_i,
  input  logic [31:0] overlay_argb_i,
  input  logic [7:0]  top_index_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  entry_red_i,
  input  logic [7:0]  entry_green_i,
  input  logic [7:0]  entry_blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] pixel_argb_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic CFG_IDX_GREEN = 1'b0;

  logic green_mode_q;
  logic cfg_wr;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Configuration port: register index is the word address.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_GREEN);
  assign prdata = (paddr[2] == CFG_IDX_GREEN) ? {31'd0, green_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      green_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      green_mode_q <= pwdata[0];
    end
  end

  poc_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .base_index_i   (base_index_i),
    .overlay_argb_i (overlay_argb_i),
    .top_index_i    (top_index_i),
    .entry_index_i  (entry_index_i),
    .entry_red_i    (entry_red_i),
    .entry_green_i  (entry_green_i),
    .entry_blue_i   (entry_blue_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  poc_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .green_mode_i (green_mode_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_argb_o (pixel_argb_o)
  );

endmodule
